/* design/ffpa_pkg.sv */
`timescale 1ns / 1ps
package ffpa_pkg;

   localparam int MaxRecordsDefault = 64;
   localparam int OffsetBitsDefault = 32;
   localparam int FieldBits         = 32;
   localparam logic [FieldBits-1:0] PoolBytesReset = '1;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   // control bits of the search token that walks the chain
   typedef struct packed {
      logic     active;
      mode_type mode;
      logic     done;
      logic     ok;
      logic     append;
      logic     bump_ok;
      logic     not_full;
      logic     bumped;
      logic     grew;
   } token_ctl_type;

endpackage

/* design/ffpa_req_if.sv */
`timescale 1ns / 1ps
interface ffpa_req_if;
   import ffpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [FieldBits-1:0] req_size;
   logic [FieldBits-1:0] free_address;
   modport source (output valid, mode, req_size, free_address, input ready);
   modport sink (input valid, mode, req_size, free_address, output ready);
endinterface

/* design/ffpa_rsp_if.sv */
`timescale 1ns / 1ps
interface ffpa_rsp_if;
   import ffpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [FieldBits-1:0] block_offset;
   logic                 ok;
   modport source (output valid, block_offset, ok, input ready);
   modport sink (input valid, block_offset, ok, output ready);
endinterface

/* design/ffpa_cell.sv */
`timescale 1ns / 1ps
module ffpa_cell
   import ffpa_pkg::*;
#(
   parameter int IDX = 0,
   parameter int OB  = OffsetBitsDefault,
   parameter int CW  = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  token_ctl_type ctl_in,
   input  logic [OB-1:0] size_in,
   input  logic [OB-1:0] addr_in,
   input  logic [OB-1:0] aoff_in,
   input  logic [OB-1:0] acap_in,
   input  logic [OB-1:0] aused_in,
   input  logic [OB-1:0] ofs_in,
   input  logic [CW-1:0] cnt_in,
   output token_ctl_type ctl_out,
   output logic [OB-1:0] size_out,
   output logic [OB-1:0] addr_out,
   output logic [OB-1:0] aoff_out,
   output logic [OB-1:0] acap_out,
   output logic [OB-1:0] aused_out,
   output logic [OB-1:0] ofs_out,
   output logic [CW-1:0] cnt_out
);

   token_ctl_type ctl_ff, ctl_in_n;
   logic [OB-1:0] size_ff, addr_ff, aoff_ff, acap_ff, aused_ff, ofs_ff;
   logic [OB-1:0] aoff_in_n, acap_in_n, aused_in_n, ofs_in_n;
   logic [CW-1:0] cnt_ff;
   logic [OB-1:0] off_ff, cap_ff, used_ff, off_in, cap_in, used_in;
   logic          free_ff, free_in;
   logic          rec_valid;
   logic [OB-1:0] slack, tail;

   assign rec_valid = CW'(IDX) < cnt_in;
   assign slack     = (used_ff <= cap_ff) ? cap_ff - used_ff : '0;
   assign tail      = off_ff + used_ff;

   always_comb begin
      ctl_in_n   = ctl_in;
      aoff_in_n  = aoff_in;
      acap_in_n  = acap_in;
      aused_in_n = aused_in;
      ofs_in_n   = ofs_in;
      off_in     = off_ff;
      cap_in     = cap_ff;
      used_in    = used_ff;
      free_in    = free_ff;
      if (ctl_in.active) begin
         if (rec_valid) begin
            if (!ctl_in.done) begin
               if (ctl_in.mode == MODE_FREE) begin
                  if (off_ff == addr_in) begin
                     free_in      = 1'b1;
                     used_in      = '0;
                     ctl_in_n.done = 1'b1;
                     ctl_in_n.ok   = 1'b1;
                     ofs_in_n     = '0;
                  end
               end else if (free_ff && cap_ff >= size_in) begin
                  free_in       = 1'b0;
                  used_in       = size_in;
                  ctl_in_n.done = 1'b1;
                  ctl_in_n.ok   = 1'b1;
                  ofs_in_n      = off_ff;
               end else if (slack >= size_in && ctl_in.not_full) begin
                  // split the unused tail into a new record at the end
                  cap_in          = used_ff;
                  ctl_in_n.done   = 1'b1;
                  ctl_in_n.ok     = 1'b1;
                  ctl_in_n.append = 1'b1;
                  ofs_in_n        = tail;
                  aoff_in_n       = tail;
                  acap_in_n       = slack;
                  aused_in_n      = size_in;
               end
            end
         end else if (ctl_in.append || (!ctl_in.done && ctl_in.mode == MODE_ALLOC
                                        && ctl_in.bump_ok)) begin
            // first empty slot takes the appended record, or a bump allocation at the end
            off_in          = aoff_in;
            cap_in          = acap_in;
            used_in         = aused_in;
            free_in         = 1'b0;
            ctl_in_n.grew   = 1'b1;
            ctl_in_n.append = 1'b0;
            if (!ctl_in.append) begin
               ctl_in_n.done   = 1'b1;
               ctl_in_n.ok     = 1'b1;
               ctl_in_n.bumped = 1'b1;
               ofs_in_n        = aoff_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_n;
      end
      size_ff  <= size_in;
      addr_ff  <= addr_in;
      aoff_ff  <= aoff_in_n;
      acap_ff  <= acap_in_n;
      aused_ff <= aused_in_n;
      ofs_ff   <= ofs_in_n;
      cnt_ff   <= cnt_in;
      off_ff   <= off_in;
      cap_ff   <= cap_in;
      used_ff  <= used_in;
      free_ff  <= free_in;
   end

   assign ctl_out   = ctl_ff;
   assign size_out  = size_ff;
   assign addr_out  = addr_ff;
   assign aoff_out  = aoff_ff;
   assign acap_out  = acap_ff;
   assign aused_out = aused_ff;
   assign ofs_out   = ofs_ff;
   assign cnt_out   = cnt_ff;

endmodule

/* design/first_fit_pool_allocator_top.sv */
`timescale 1ns / 1ps
// the search token walks the row of record cells one cell per cycle, then the
// response is held until taken; a new request is accepted only while idle,
// after the previous response has been taken
// reset: synchronous, clears record count, end offset and the token chain;
// pool_bytes returns to all ones, record contents stay undefined
module first_fit_pool_allocator_top
   import ffpa_pkg::*;
#(
   parameter int MAX_RECORDS = MaxRecordsDefault,
   parameter int OFFSET_BITS = OffsetBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   ffpa_req_if.sink             req,
   ffpa_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [FieldBits-1:0] csr_wdata
);

   localparam int OB = OFFSET_BITS;
   localparam int CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [OB:0]   end_ff, end_in;
   logic [OB-1:0] pool_ff;
   logic [FieldBits-1:0] rsp_ofs_ff, rsp_ofs_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic          fire, not_full, bump_ok;
   logic [OB-1:0] size_w;
   logic [OB+1:0] bump_end;

   token_ctl_type ctl [MAX_RECORDS+1];
   logic [OB-1:0] size_c [MAX_RECORDS+1];
   logic [OB-1:0] addr_c [MAX_RECORDS+1];
   logic [OB-1:0] aoff_c [MAX_RECORDS+1];
   logic [OB-1:0] acap_c [MAX_RECORDS+1];
   logic [OB-1:0] aused_c [MAX_RECORDS+1];
   logic [OB-1:0] ofs_c [MAX_RECORDS+1];
   logic [CW-1:0] cnt_c [MAX_RECORDS+1];
   token_ctl_type last;

   assign fire     = req.valid && req.ready;
   assign req.ready = state_ff == ST_IDLE;
   assign size_w   = OB'(req.req_size);
   assign not_full = count_ff < CW'(MAX_RECORDS);
   assign bump_end = {1'b0, end_ff} + (OB+2)'(size_w);
   assign bump_ok  = not_full && !(end_ff >= {1'b0, pool_ff})
                     && !(bump_end > (OB+2)'(pool_ff));

   always_comb begin
      ctl[0]          = '0;
      ctl[0].active   = fire;
      ctl[0].mode     = mode_type'(req.mode);
      ctl[0].bump_ok  = bump_ok;
      ctl[0].not_full = not_full;
      size_c[0]       = size_w;
      addr_c[0]       = OB'(req.free_address);
      aoff_c[0]       = end_ff[OB-1:0];
      acap_c[0]       = size_w;
      aused_c[0]      = size_w;
      ofs_c[0]        = '0;
      cnt_c[0]        = count_ff;
   end

   for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
      ffpa_cell #(.IDX(g), .OB(OB), .CW(CW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl_in    (ctl[g]),
         .size_in   (size_c[g]),
         .addr_in   (addr_c[g]),
         .aoff_in   (aoff_c[g]),
         .acap_in   (acap_c[g]),
         .aused_in  (aused_c[g]),
         .ofs_in    (ofs_c[g]),
         .cnt_in    (cnt_c[g]),
         .ctl_out   (ctl[g+1]),
         .size_out  (size_c[g+1]),
         .addr_out  (addr_c[g+1]),
         .aoff_out  (aoff_c[g+1]),
         .acap_out  (acap_c[g+1]),
         .aused_out (aused_c[g+1]),
         .ofs_out   (ofs_c[g+1]),
         .cnt_out   (cnt_c[g+1])
      );
   end

   assign last = ctl[MAX_RECORDS];

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      end_in     = end_ff;
      rsp_ofs_in = rsp_ofs_ff;
      rsp_ok_in  = rsp_ok_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fire) state_in = ST_BUSY;
         end
         ST_BUSY: begin
            if (last.active) begin
               state_in   = ST_RESP;
               rsp_ok_in  = last.done && last.ok;
               rsp_ofs_in = (last.done && last.ok) ?
                            FieldBits'(ofs_c[MAX_RECORDS]) : '0;
               if (last.grew) count_in = count_ff + CW'(1);
               if (last.bumped) end_in = end_ff + (OB+1)'(size_c[MAX_RECORDS]);
            end
         end
         ST_RESP: begin
            if (rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         end_ff   <= '0;
         pool_ff  <= OB'(PoolBytesReset);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         end_ff   <= end_in;
         if (csr_we) pool_ff <= OB'(csr_wdata);
      end
      rsp_ofs_ff <= rsp_ofs_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp.valid        = state_ff == ST_RESP;
   assign rsp.block_offset = rsp_ofs_ff;
   assign rsp.ok           = rsp_ok_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS))
      else $error("record count past table size");
   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      last.active |-> state_ff == ST_BUSY)
      else $error("token left chain outside busy state");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ok |-> rsp.block_offset == '0)
      else $error("failed request with nonzero offset");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> count_ff == $past(count_ff))
      else $error("record count moved while idle");

endmodule
